// ----- rtl/sha1s_pkg.sv -----
// shared constants, interface structs and round functions for the sha-1 stream hasher
package sha1s_pkg;

    // round constants
    localparam logic [31:0] K_0 = 32'h5a827999;
    localparam logic [31:0] K_1 = 32'h6ed9eba1;
    localparam logic [31:0] K_2 = 32'h8f1bbcdc;
    localparam logic [31:0] K_3 = 32'hca62c1d6;

    // initial chaining values
    localparam logic [31:0] IV_0 = 32'h67452301;
    localparam logic [31:0] IV_1 = 32'hefcdab89;
    localparam logic [31:0] IV_2 = 32'h98badcfe;
    localparam logic [31:0] IV_3 = 32'h10325476;
    localparam logic [31:0] IV_4 = 32'hc3d2e1f0;

    // padding marker byte
    localparam logic [7:0] PAD_MARK = 8'h80;

    // round group boundaries
    localparam logic [6:0] ROUND_B1     = 7'd20;
    localparam logic [6:0] ROUND_B2     = 7'd40;
    localparam logic [6:0] ROUND_B3     = 7'd60;
    localparam logic [6:0] LAST_ROUND   = 7'd79;
    localparam logic [6:0] SCHED_ROUNDS = 7'd16;

    // number of chaining words
    localparam int unsigned CHAIN_N = 5;

    // commands from the controller to the round core
    typedef struct packed {
        logic       start;
        logic       init;
        logic       rd_en;
        logic [2:0] rd_idx;
    } t_core_cmd;

    // round core status
    typedef struct packed {
        logic busy;
        logic done;
    } t_core_sts;

    // block buffer read request
    typedef struct packed {
        logic       en;
        logic [3:0] addr;
    } t_buf_rd;

    // initial value of one chaining word
    function automatic logic [31:0] chain_iv(input logic [2:0] idx);
        logic [31:0] v;
        unique case (idx)
            3'd0:    v = IV_0;
            3'd1:    v = IV_1;
            3'd2:    v = IV_2;
            3'd3:    v = IV_3;
            3'd4:    v = IV_4;
            default: v = IV_0;
        endcase
        return v;
    endfunction

    // round constant for round t
    function automatic logic [31:0] round_k(input logic [6:0] t);
        logic [31:0] k;
        priority if (t < ROUND_B1) begin
            k = K_0;
        end else if (t < ROUND_B2) begin
            k = K_1;
        end else if (t < ROUND_B3) begin
            k = K_2;
        end else begin
            k = K_3;
        end
        return k;
    endfunction

    // boolean function for round t
    function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        priority if (t < ROUND_B1) begin
            f = (b & c) | (~b & d);
        end else if (t < ROUND_B2) begin
            f = b ^ c ^ d;
        end else if (t < ROUND_B3) begin
            f = (b & c) | (b & d) | (c & d);
        end else begin
            f = b ^ c ^ d;
        end
        return f;
    endfunction

endpackage

// ----- rtl/sha1s_block_buf.sv -----
// block buffer: packs message bytes into big-endian words in a 16-word memory
module sha1s_block_buf
    import sha1s_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_wr_en,
    input  logic [7:0]  i_wr_byte,
    output logic [5:0]  o_fill,
    input  t_buf_rd     i_rd,
    output logic [31:0] o_rd_data
);

    logic [31:0] r_mem [16];
    logic [23:0] r_acc;
    logic [5:0]  r_fill;
    logic [31:0] r_rd_data;

    // byte count within the block, wraps after 64
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_wr_en) begin
            r_fill <= r_fill + 6'd1;
        end
    end

    // word assembly and memory access
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_acc <= {r_acc[15:0], i_wr_byte};
        end
        if (i_wr_en && (r_fill[1:0] == 2'd3)) begin
            r_mem[r_fill[5:2]] <= {r_acc, i_wr_byte};
        end
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    assign o_fill    = r_fill;
    assign o_rd_data = r_rd_data;

`ifndef SYNTH
    // the core reads the block only while no bytes come in
    a_no_rd_during_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr_en |-> !i_rd.en)
        else $error("block buffer read while bytes are written");
`endif

endmodule

// ----- rtl/sha1s_round_core.sv -----
// round core: chaining word memory, working registers, schedule window and round unit
module sha1s_round_core
    import sha1s_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_core_cmd   i_cmd,
    output t_core_sts   o_sts,
    output t_buf_rd     o_buf_rd,
    input  logic [31:0] i_buf_data,
    output logic [31:0] o_chain_data
);

    localparam logic [6:0] XFER_END = 7'(CHAIN_N);
    localparam logic [3:0] SCHED_LAST_RD = 4'd15;

    typedef enum logic [1:0] {C_IDLE, C_LOAD, C_ROUND, C_WB} t_state;

    t_state      r_state;
    logic [6:0]  r_cnt;
    logic        r_fresh;
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [31:0] r_sched [16];
    logic [31:0] r_chain_mem [CHAIN_N];
    logic [31:0] r_chain_q;
    logic [2:0]  r_idx_q;

    logic        chain_rd_en;
    logic [2:0]  chain_rd_idx;
    logic        chain_wr_en;
    logic [2:0]  chain_wr_idx;
    logic [31:0] chain_dout;
    logic [31:0] chain_wr_data;
    logic [31:0] w_mix, w_rot, w_cur, t_sum;
    t_buf_rd     buf_rd;

    // chaining words read as initial values until the first write-back
    assign chain_dout    = r_fresh ? chain_iv(r_idx_q) : r_chain_q;
    assign chain_wr_data = chain_dout + r_a;

    // message schedule expansion and the round sum
    assign w_mix = r_sched[2] ^ r_sched[7] ^ r_sched[13] ^ r_sched[15];
    assign w_rot = {w_mix[30:0], w_mix[31]};
    assign w_cur = (r_cnt < SCHED_ROUNDS) ? i_buf_data : w_rot;
    assign t_sum = {r_a[26:0], r_a[31:27]} + round_f(r_cnt, r_b, r_c, r_d) + r_e
                 + round_k(r_cnt) + w_cur;

    // memory access strobes per phase
    always_comb begin
        chain_rd_en  = 1'b0;
        chain_rd_idx = i_cmd.rd_idx;
        chain_wr_en  = 1'b0;
        chain_wr_idx = r_cnt[2:0] - 3'd1;
        buf_rd       = '0;
        unique case (r_state)
            C_IDLE: begin
                chain_rd_en = i_cmd.rd_en;
            end
            C_LOAD: begin
                chain_rd_en  = (r_cnt < XFER_END);
                chain_rd_idx = r_cnt[2:0];
                buf_rd.en    = (r_cnt == XFER_END);
            end
            C_ROUND: begin
                buf_rd.en   = (r_cnt[3:0] < SCHED_LAST_RD) && (r_cnt < SCHED_ROUNDS);
                buf_rd.addr = r_cnt[3:0] + 4'd1;
            end
            C_WB: begin
                chain_rd_en  = (r_cnt < XFER_END);
                chain_rd_idx = r_cnt[2:0];
                chain_wr_en  = (r_cnt != 7'd0);
            end
        endcase
    end

    // sequencer: load, 80 rounds, write-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_cnt   <= '0;
            r_fresh <= 1'b1;
        end else begin
            unique case (r_state)
                C_IDLE: begin
                    if (i_cmd.start) begin
                        r_state <= C_LOAD;
                        r_cnt   <= '0;
                    end else if (i_cmd.init) begin
                        r_fresh <= 1'b1;
                    end
                end
                C_LOAD: begin
                    if (r_cnt == XFER_END) begin
                        r_state <= C_ROUND;
                        r_cnt   <= '0;
                    end else begin
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                C_ROUND: begin
                    if (r_cnt == LAST_ROUND) begin
                        r_state <= C_WB;
                        r_cnt   <= '0;
                    end else begin
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                C_WB: begin
                    if (r_cnt == XFER_END) begin
                        r_state <= C_IDLE;
                        r_fresh <= 1'b0;
                    end else begin
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
            endcase
        end
    end

    // working registers and schedule window
    always_ff @(posedge i_clk) begin
        if (((r_state == C_LOAD) || (r_state == C_WB)) && (r_cnt != 7'd0)) begin
            r_a <= r_b;
            r_b <= r_c;
            r_c <= r_d;
            r_d <= r_e;
            r_e <= chain_dout;
        end else if (r_state == C_ROUND) begin
            r_a <= t_sum;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_d <= r_c;
            r_e <= r_d;
            r_sched[0] <= w_cur;
            for (int i = 1; i < 16; i++) begin
                r_sched[i] <= r_sched[i-1];
            end
        end
    end

    // chaining word memory
    always_ff @(posedge i_clk) begin
        if (chain_wr_en) begin
            r_chain_mem[chain_wr_idx] <= chain_wr_data;
        end
        if (chain_rd_en) begin
            r_chain_q <= r_chain_mem[chain_rd_idx];
            r_idx_q   <= chain_rd_idx;
        end
    end

    assign o_sts.busy   = (r_state != C_IDLE);
    assign o_sts.done   = (r_state == C_WB) && (r_cnt == XFER_END);
    assign o_buf_rd     = buf_rd;
    assign o_chain_data = chain_dout;

`ifndef SYNTH
    // a compression starts only from idle
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start |-> (r_state == C_IDLE))
        else $error("compression start while core busy");

    // after write-back the memory holds real chaining words
    a_done_stored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_sts.done |=> (r_state == C_IDLE) && !r_fresh)
        else $error("write-back did not complete");
`endif

endmodule

// ----- rtl/sha1_stream_hasher.sv -----
// sha-1 stream hasher top: byte intake, padding sequencer and digest output
// an item without end of message leaves the hasher idle and ready for the next; a completed 64-byte block
// holds the intake through a compression (chaining word load, 80 rounds on one round unit, write-back)
// end of message: padding bytes at one per cycle, paused while a full block compresses, with a turn step
// that writes no byte before the length, one or two compressions, then each digest word is read, loaded and sent
// reset: synchronous active low; chaining words read as initial values, counts cleared at once
module sha1_stream_hasher
    import sha1s_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_end_of_message,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    localparam logic [5:0] FILL_LAST  = 6'd63;
    localparam logic [5:0] PAD_LEN_AT = 6'd56;
    localparam logic [2:0] LAST_IDX   = 3'd4;
    localparam logic [2:0] LEN_LAST   = 3'd7;

    typedef enum logic [2:0] {S_IDLE, S_PAD, S_COMP, S_RDWORD, S_LDWORD, S_SEND} t_state;
    typedef enum logic [1:0] {P_MARK, P_ZERO, P_LEN} t_pad;

    t_state      r_state;
    t_state      r_resume;
    t_pad        r_pad;
    logic [2:0]  r_len_cnt;
    logic [63:0] r_msg_bytes;
    logic [2:0]  r_word_idx;
    logic        r_out_valid;
    logic [31:0] r_digest_word;
    logic [2:0]  r_word_index;
    logic        r_last_word;

    logic        in_xfer;
    logic        out_xfer;
    logic        buf_wr;
    logic [7:0]  buf_byte;
    logic        block_full;
    logic [63:0] len_bits;
    logic [63:0] len_shifted;
    logic [5:0]  buf_fill;
    logic [31:0] buf_data;
    logic [31:0] chain_data;
    t_buf_rd     buf_rd;
    t_core_cmd   core_cmd;
    t_core_sts   core_sts;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign out_xfer   = r_out_valid && i_out_ready;

    // big-endian length byte selected by the length counter
    assign len_bits    = {r_msg_bytes[60:0], 3'b000};
    assign len_shifted = len_bits >> {~r_len_cnt, 3'b000};

    // byte source: message bytes or padding
    always_comb begin
        buf_wr   = 1'b0;
        buf_byte = i_data_byte;
        if (r_state == S_IDLE) begin
            buf_wr = in_xfer && i_byte_present;
        end else if (r_state == S_PAD) begin
            unique case (r_pad)
                P_MARK: begin
                    buf_wr   = 1'b1;
                    buf_byte = PAD_MARK;
                end
                P_ZERO: begin
                    buf_wr   = (buf_fill != PAD_LEN_AT);
                    buf_byte = '0;
                end
                P_LEN: begin
                    buf_wr   = 1'b1;
                    buf_byte = len_shifted[7:0];
                end
                default: begin
                    buf_wr   = 1'b0;
                    buf_byte = '0;
                end
            endcase
        end
    end

    assign block_full = buf_wr && (buf_fill == FILL_LAST);

    // core commands
    assign core_cmd.start  = block_full;
    assign core_cmd.init   = out_xfer && r_last_word;
    assign core_cmd.rd_en  = (r_state == S_RDWORD);
    assign core_cmd.rd_idx = r_word_idx;

    // controller state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_resume      <= S_IDLE;
            r_pad         <= P_MARK;
            r_len_cnt     <= '0;
            r_msg_bytes   <= '0;
            r_word_idx    <= '0;
            r_out_valid   <= 1'b0;
            r_digest_word <= '0;
            r_word_index  <= '0;
            r_last_word   <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_pad      <= P_MARK;
                        r_word_idx <= '0;
                        if (i_byte_present) begin
                            r_msg_bytes <= r_msg_bytes + 64'd1;
                        end
                        if (block_full) begin
                            r_state  <= S_COMP;
                            r_resume <= i_end_of_message ? S_PAD : S_IDLE;
                        end else if (i_end_of_message) begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    unique case (r_pad)
                        P_MARK: begin
                            r_pad <= P_ZERO;
                        end
                        P_ZERO: begin
                            if (buf_fill == PAD_LEN_AT) begin
                                r_pad     <= P_LEN;
                                r_len_cnt <= '0;
                            end
                        end
                        P_LEN: begin
                            r_len_cnt <= r_len_cnt + 3'd1;
                        end
                        default: begin
                            r_pad <= P_MARK;
                        end
                    endcase
                    if (block_full) begin
                        r_state  <= S_COMP;
                        r_resume <= ((r_pad == P_LEN) && (r_len_cnt == LEN_LAST))
                                    ? S_RDWORD : S_PAD;
                    end
                end
                S_COMP: begin
                    if (core_sts.done) begin
                        r_state <= r_resume;
                    end
                end
                S_RDWORD: begin
                    r_state <= S_LDWORD;
                end
                S_LDWORD: begin
                    r_out_valid   <= 1'b1;
                    r_digest_word <= chain_data;
                    r_word_index  <= r_word_idx;
                    r_last_word   <= (r_word_idx == LAST_IDX);
                    r_state       <= S_SEND;
                end
                S_SEND: begin
                    if (out_xfer) begin
                        r_out_valid <= 1'b0;
                        if (r_last_word) begin
                            r_state     <= S_IDLE;
                            r_msg_bytes <= '0;
                        end else begin
                            r_word_idx <= r_word_idx + 3'd1;
                            r_state    <= S_RDWORD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    sha1s_block_buf u_block_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (buf_wr),
        .i_wr_byte (buf_byte),
        .o_fill    (buf_fill),
        .i_rd      (buf_rd),
        .o_rd_data (buf_data)
    );

    sha1s_round_core u_round_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (core_cmd),
        .o_sts        (core_sts),
        .o_buf_rd     (buf_rd),
        .i_buf_data   (buf_data),
        .o_chain_data (chain_data)
    );

    assign o_out_valid   = r_out_valid;
    assign o_digest_word = r_digest_word;
    assign o_word_index  = r_word_index;
    assign o_last_word   = r_last_word;

`ifndef SYNTH
    // no new item is taken while a digest word waits
    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input accepted while digest pending");

    // the block buffer is never written under a running compression
    a_wr_core_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        buf_wr |-> !core_sts.busy)
        else $error("buffer write during compression");

    // compression completes only while the controller waits for it
    a_done_in_comp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_sts.done |-> (r_state == S_COMP))
        else $error("unexpected compression done");
`endif

endmodule
